>>> rtl/core/prrs_pkg.sv
package prrs_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_CPUS_DEF    = 8;
    localparam int CPU_W           = 4;
    localparam int TIME_W          = 16;

    localparam logic FUNC_ADMIT = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic KIND_ADMIT = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic [1:0] {
        MARK_READY   = 2'd0,
        MARK_RUNNING = 2'd1,
        MARK_RAN     = 2'd2
    } mark_t;

    typedef struct packed {
        logic        func;
        logic [7:0]  job_tag;
        logic [7:0]  job_priority;
        logic [15:0] job_duration;
    } cmd_t;

    typedef struct packed {
        logic             result_kind;
        logic             admit_ok;
        logic [CPU_W-1:0] cpu_number;
        logic             cpu_idle;
        logic             idle_start;
        logic [7:0]       run_tag;
        logic             job_done;
        logic [15:0]      finish_time;
        logic [15:0]      time_stamp;
        logic             last;
    } result_t;

endpackage

>>> rtl/core/priority_round_robin_cpu_scheduler.sv
// Priority round-robin scheduler over a table of jobs sorted by priority.
// An item is taken on start while busy is low. func selects admit or tick.
// An admit item produces one result with last set; admit_ok is set unless
// the table is full, in which case no walk happens. Otherwise it walks the table
// from the top, moving one entry per cycle to open a slot.
// A tick item produces one report per served CPU, last set on the final one.
// Each CPU scans the table one entry per cycle with a single compare unit.
// After the last CPU the table is compacted one entry per cycle, removing
// finished jobs. Each result shows on result for one cycle with
// result_valid high; the receiver cannot stall it. busy is high from
// acceptance until the item is fully finished, but a rejected admit leaves
// it low. cfg_we writes cpu_count (4 bits); the user must do so only while
// idle, as the block itself does not enforce it.
// Reset empties the table, clears the time counter and the per-CPU busy
// history, and sets cpu_count to 1.
module priority_round_robin_cpu_scheduler #(
    parameter int TABLE_DEPTH = prrs_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_CPUS    = prrs_pkg::MAX_CPUS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  prrs_pkg::cmd_t              cmd,
    input  logic                        cfg_we,
    input  logic [prrs_pkg::CPU_W-1:0]  cfg_data,
    output logic                        result_valid,
    output prrs_pkg::result_t           result
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW   = $clog2(TABLE_DEPTH + 1);
    localparam int CIW  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CPUW = prrs_pkg::CPU_W;
    localparam int TW   = prrs_pkg::TIME_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN,
        S_COMPACT
    } state_t;

    state_t                state_reg, state_next;
    logic [NW-1:0]         used_reg, used_next;
    logic [NW-1:0]         j_reg, j_next;
    logic [NW-1:0]         ls_reg, ls_next;
    logic [NW-1:0]         w_reg, w_next;
    logic [AW-1:0]         first_ran_reg, first_ran_next;
    logic                  any_ran_reg, any_ran_next;
    logic [CIW-1:0]        cpu_reg, cpu_next;
    logic [CPUW-1:0]       cpus_reg, cpus_next;
    logic [CPUW-1:0]       cpu_count_reg, cpu_count_next;
    logic [TW-1:0]         time_reg, time_next;
    logic [(1<<CIW)-1:0]   busy_hist_reg, busy_hist_next;
    logic                  valid_reg, valid_next;
    prrs_pkg::result_t     res_reg, res_next;
    prrs_pkg::cmd_t        cmd_reg, cmd_next;

    logic [7:0]            prio_mem [TABLE_DEPTH];
    logic [15:0]           rem_mem  [TABLE_DEPTH];
    logic [7:0]            tag_mem  [TABLE_DEPTH];
    prrs_pkg::mark_t       mark_mem [TABLE_DEPTH];

    // Table write controls produced by the sequencer.
    logic                  wr_new, wr_move, wr_copy, do_pick, do_reset, do_run;
    logic [AW-1:0]         wr_idx, src_idx, pick_idx;
    logic [AW-1:0]         j_idx, ls_idx, k_idx;
    logic [NW-1:0]         k_m1;
    logic                  at_end, lvl_end;
    logic [TW-1:0]         fin;
    logic [CPUW-1:0]       cpus_clamped;
    logic [CPUW-1:0]       cpu_num;
    logic                  last_cpu;

    assign j_idx   = j_reg[AW-1:0];
    assign ls_idx  = ls_reg[AW-1:0];
    assign k_m1    = j_reg - NW'(1);
    assign k_idx   = k_m1[AW-1:0];
    assign fin     = (time_reg == prrs_pkg::TIME_MAX) ? time_reg : time_reg + TW'(1);
    assign at_end  = (j_reg == used_reg);
    assign lvl_end = at_end || ((j_reg != ls_reg) && (prio_mem[j_idx] != prio_mem[ls_idx]));
    assign cpu_num = CPUW'(cpu_reg) + CPUW'(1);
    assign last_cpu = (cpu_num == cpus_reg);

    always_comb
    begin
        if (cpu_count_reg == '0)
            cpus_clamped = CPUW'(1);
        else if (32'(cpu_count_reg) > MAX_CPUS)
            cpus_clamped = CPUW'(MAX_CPUS);
        else
            cpus_clamped = cpu_count_reg;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        j_next         = j_reg;
        ls_next        = ls_reg;
        w_next         = w_reg;
        first_ran_next = first_ran_reg;
        any_ran_next   = any_ran_reg;
        cpu_next       = cpu_reg;
        cpus_next      = cpus_reg;
        cpu_count_next = cfg_we ? cfg_data : cpu_count_reg;
        time_next      = time_reg;
        busy_hist_next = busy_hist_reg;
        valid_next     = 1'b0;
        res_next       = '0;
        cmd_next       = cmd_reg;
        wr_new         = 1'b0;
        wr_move        = 1'b0;
        wr_copy        = 1'b0;
        do_pick        = 1'b0;
        do_reset       = 1'b0;
        do_run         = 1'b0;
        wr_idx         = j_idx;
        src_idx        = k_idx;
        pick_idx       = j_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    j_next   = '0;
                    ls_next  = '0;
                    any_ran_next = 1'b0;
                    if (cmd.func == prrs_pkg::FUNC_ADMIT)
                    begin
                        if (32'(used_reg) >= TABLE_DEPTH)
                        begin
                            valid_next           = 1'b1;
                            res_next.result_kind = prrs_pkg::KIND_ADMIT;
                            res_next.last        = 1'b1;
                        end
                        else
                        begin
                            j_next     = used_reg;
                            state_next = S_INSERT;
                        end
                    end
                    else
                    begin
                        cpu_next   = '0;
                        cpus_next  = cpus_clamped;
                        state_next = S_SCAN;
                    end
                end
            end

            S_INSERT:
            begin
                // Walk down from the top; each cycle moves one lower-priority entry up.
                if ((j_reg != '0) && (prio_mem[k_idx] > cmd_reg.job_priority))
                begin
                    wr_move = 1'b1;
                    wr_idx  = j_idx;
                    src_idx = k_idx;
                    j_next  = k_m1;
                end
                else
                begin
                    wr_new               = 1'b1;
                    wr_idx               = j_idx;
                    used_next            = used_reg + NW'(1);
                    valid_next           = 1'b1;
                    res_next.result_kind = prrs_pkg::KIND_ADMIT;
                    res_next.admit_ok    = 1'b1;
                    res_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            S_SCAN:
            begin
                res_next.result_kind = prrs_pkg::KIND_TICK;
                res_next.cpu_number  = cpu_num;
                res_next.time_stamp  = time_reg;
                res_next.last        = last_cpu;
                if (lvl_end)
                begin
                    if (any_ran_reg)
                    begin
                        // No ready job is left in the level but some have run: make the ran ones ready, take the first.
                        do_pick  = 1'b1;
                        do_reset = 1'b1;
                        pick_idx = first_ran_reg;
                    end
                    else if (at_end)
                    begin
                        valid_next          = 1'b1;
                        res_next.cpu_idle   = 1'b1;
                        res_next.idle_start = busy_hist_reg[cpu_reg];
                        busy_hist_next[cpu_reg] = 1'b0;
                    end
                    else
                    begin
                        ls_next      = j_reg;
                        any_ran_next = 1'b0;
                    end
                end
                else
                begin
                    j_next = j_reg + NW'(1);
                    if ((mark_mem[j_idx] == prrs_pkg::MARK_READY) && (rem_mem[j_idx] != '0))
                    begin
                        do_pick  = 1'b1;
                        do_run   = 1'b1;
                        pick_idx = j_idx;
                    end
                    else if ((mark_mem[j_idx] == prrs_pkg::MARK_RAN) && (rem_mem[j_idx] != '0))
                    begin
                        if (!any_ran_reg)
                            first_ran_next = j_idx;
                        any_ran_next = 1'b1;
                    end
                end

                if (do_pick)
                begin
                    valid_next       = 1'b1;
                    res_next.run_tag = tag_mem[pick_idx];
                    if (rem_mem[pick_idx] == 16'd1)
                    begin
                        res_next.job_done    = 1'b1;
                        res_next.finish_time = fin;
                    end
                    busy_hist_next[cpu_reg] = 1'b1;
                end

                if (valid_next)
                begin
                    j_next       = '0;
                    ls_next      = '0;
                    any_ran_next = 1'b0;
                    if (last_cpu)
                    begin
                        w_next     = '0;
                        state_next = S_COMPACT;
                    end
                    else
                        cpu_next = cpu_reg + CIW'(1);
                end
            end

            S_COMPACT:
            begin
                if (at_end)
                begin
                    used_next  = w_reg;
                    time_next  = fin;
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next = j_reg + NW'(1);
                    if (rem_mem[j_idx] != '0)
                    begin
                        wr_copy = 1'b1;
                        wr_idx  = w_reg[AW-1:0];
                        src_idx = j_idx;
                        w_next  = w_reg + NW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            j_reg         <= '0;
            ls_reg        <= '0;
            w_reg         <= '0;
            first_ran_reg <= '0;
            any_ran_reg   <= 1'b0;
            cpu_reg       <= '0;
            cpus_reg      <= CPUW'(1);
            cpu_count_reg <= CPUW'(1);
            time_reg      <= '0;
            busy_hist_reg <= '0;
            valid_reg     <= 1'b0;
            res_reg       <= '0;
            cmd_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            j_reg         <= j_next;
            ls_reg        <= ls_next;
            w_reg         <= w_next;
            first_ran_reg <= first_ran_next;
            any_ran_reg   <= any_ran_next;
            cpu_reg       <= cpu_next;
            cpus_reg      <= cpus_next;
            cpu_count_reg <= cpu_count_next;
            time_reg      <= time_next;
            busy_hist_reg <= busy_hist_next;
            valid_reg     <= valid_next;
            res_reg       <= res_next;
            cmd_reg       <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_new)
        begin
            prio_mem[wr_idx] <= cmd_reg.job_priority;
            rem_mem[wr_idx]  <= cmd_reg.job_duration;
            tag_mem[wr_idx]  <= cmd_reg.job_tag;
            mark_mem[wr_idx] <= prrs_pkg::MARK_READY;
        end
        else if (wr_move)
        begin
            prio_mem[wr_idx] <= prio_mem[src_idx];
            rem_mem[wr_idx]  <= rem_mem[src_idx];
            tag_mem[wr_idx]  <= tag_mem[src_idx];
            mark_mem[wr_idx] <= mark_mem[src_idx];
        end
        else if (wr_copy)
        begin
            prio_mem[wr_idx] <= prio_mem[src_idx];
            rem_mem[wr_idx]  <= rem_mem[src_idx];
            tag_mem[wr_idx]  <= tag_mem[src_idx];
            mark_mem[wr_idx] <= (mark_mem[src_idx] == prrs_pkg::MARK_RUNNING) ?
                                prrs_pkg::MARK_RAN : mark_mem[src_idx];
        end

        if (do_reset)
        begin
            for (int k = 0; k < TABLE_DEPTH; k++)
            begin
                if ((NW'(k) >= ls_reg) && (NW'(k) < j_reg)
                    && (mark_mem[k] == prrs_pkg::MARK_RAN))
                    mark_mem[k] <= (AW'(k) == pick_idx) ?
                                   prrs_pkg::MARK_RUNNING : prrs_pkg::MARK_READY;
            end
        end
        else if (do_run)
            mark_mem[pick_idx] <= prrs_pkg::MARK_RUNNING;

        if (do_pick)
            rem_mem[pick_idx] <= rem_mem[pick_idx] - 16'd1;
    end

endmodule
